[rtl/bbc_pkg.sv]
`timescale 1ns / 1ps
package bbc_pkg;

  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_DWRITE  = 3'd4;
  localparam logic [2:0] OP_FLUSH   = 3'd5;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_WRITEBACK = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  device;
    logic [23:0] block_number;
    logic [3:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  granted_buffer;
    logic [7:0]  wb_device;
    logic [23:0] wb_block;
    logic        need_read;
    logic        last;
  } res_t;

endpackage

[rtl/bbc_cell.sv]
`timescale 1ns / 1ps
module bbc_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    key_dev,
  input  logic [23:0]   key_blk,
  input  logic          wr_en,
  input  logic [7:0]    wr_dev,
  input  logic [23:0]   wr_blk,
  input  logic          probe_vld_in,
  input  logic          probe_hit_in,
  input  logic [IW-1:0] probe_idx_in,
  output logic          probe_vld_out,
  output logic          probe_hit_out,
  output logic [IW-1:0] probe_idx_out,
  output logic [7:0]    tag_dev,
  output logic [23:0]   tag_blk,
  output logic          valid
);

  logic match;
  assign match = valid && (tag_dev == key_dev) && (tag_blk == key_blk);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      probe_vld_out <= 1'b0;
    end else begin
      if (wr_en) begin
        valid <= 1'b1;
      end
      probe_vld_out <= probe_vld_in;
    end
  end

  // payload: tag and probe data need no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_dev <= wr_dev;
      tag_blk <= wr_blk;
    end
    // an earlier hit wins, so the lowest index is kept
    probe_hit_out <= probe_hit_in | match;
    probe_idx_out <= probe_hit_in ? probe_idx_in : IW'(IDX);
  end

endmodule

[rtl/block_buffer_cache_lru_core.sv]
`timescale 1ns / 1ps
// Buffer cache with an LRU free list. A request is taken when start is high and busy is low;
// each result shows on result for one cycle with strobe high, and the receiver cannot stall,
// so results must be taken as they come. Release, write, delayed write and unknown opcodes
// finish straight from idle. Get and read send a probe down the row of NUM_BUFFERS tag
// cells, one cell per cycle; on a miss the list head is then taken once per cycle: a dirty
// head gets a write-back result and moves to the tail, and a clean head is popped with the
// miss result. Flush walks the free list one buffer per cycle, at most NUM_BUFFERS of them.
module block_buffer_cache_lru_core #(
  parameter int NUM_BUFFERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bbc_pkg::req_t req,
  output logic          strobe,
  output bbc_pkg::res_t result
);

  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int LW = $clog2(NUM_BUFFERS + 1);
  localparam logic [LW-1:0] NONE = LW'(NUM_BUFFERS);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_ALLOC, S_FLUSH} state_t;
  state_t state;

  logic [7:0]    key_dev;
  logic [23:0]   key_blk;
  logic          is_read;
  logic          inject;
  logic [LW-1:0] walk;
  logic [LW-1:0] steps;

  logic          busy_f  [NUM_BUFFERS];
  logic          done_f  [NUM_BUFFERS];
  logic          dirty_f [NUM_BUFFERS];
  logic [LW-1:0] next_l  [NUM_BUFFERS];
  logic [LW-1:0] prev_l  [NUM_BUFFERS];
  logic [LW-1:0] head;
  logic [LW-1:0] tail;

  logic          pv [NUM_BUFFERS+1];
  logic          ph [NUM_BUFFERS+1];
  logic [IW-1:0] pi [NUM_BUFFERS+1];
  logic [7:0]    cdev [NUM_BUFFERS];
  logic [23:0]   cblk [NUM_BUFFERS];
  logic          cval [NUM_BUFFERS];
  logic          cwr  [NUM_BUFFERS];

  logic [IW-1:0] head_idx;
  logic [IW-1:0] req_idx;
  logic [IW-1:0] walk_idx;
  logic [IW-1:0] hit_idx;
  logic          req_in_range;
  logic          alloc_fire;

  assign busy         = (state != S_IDLE);
  assign head_idx     = head[IW-1:0];
  assign walk_idx     = walk[IW-1:0];
  assign hit_idx      = pi[NUM_BUFFERS];
  assign req_in_range = ({28'd0, req.buffer_index} < 32'(NUM_BUFFERS));
  assign req_idx      = IW'(req.buffer_index);
  assign alloc_fire   = (state == S_ALLOC) && (head != NONE) && !dirty_f[head_idx];

  assign pv[0] = inject;
  assign ph[0] = 1'b0;
  assign pi[0] = '0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    assign cwr[g] = alloc_fire && (head_idx == IW'(g));
    bbc_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk(clk), .rst(rst), .key_dev(key_dev), .key_blk(key_blk),
      .wr_en(cwr[g]), .wr_dev(key_dev), .wr_blk(key_blk),
      .probe_vld_in(pv[g]), .probe_hit_in(ph[g]), .probe_idx_in(pi[g]),
      .probe_vld_out(pv[g+1]), .probe_hit_out(ph[g+1]), .probe_idx_out(pi[g+1]),
      .tag_dev(cdev[g]), .tag_blk(cblk[g]), .valid(cval[g])
    );
  end

  function automatic bbc_pkg::res_t mk(logic [2:0] st, logic [IW-1:0] b, logic [7:0] d,
                                       logic [23:0] k, logic nr, logic l);
    bbc_pkg::res_t r;
    r.status         = st;
    r.granted_buffer = 4'(32'(b));
    r.wb_device      = d;
    r.wb_block       = k;
    r.need_read      = nr;
    r.last           = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      inject <= 1'b0;
      head   <= '0;
      tail   <= LW'(NUM_BUFFERS - 1);
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        busy_f[i]  <= 1'b0;
        done_f[i]  <= 1'b0;
        dirty_f[i] <= 1'b0;
        next_l[i]  <= LW'(i + 1);
        prev_l[i]  <= (i == 0) ? NONE : LW'(i - 1);
      end
    end else begin
      strobe <= 1'b0;
      inject <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key_dev <= req.device;
            key_blk <= req.block_number;
            is_read <= (req.opcode == bbc_pkg::OP_READ);
            if (req.opcode == bbc_pkg::OP_GET || req.opcode == bbc_pkg::OP_READ) begin
              inject <= 1'b1;
              state  <= S_SEARCH;
            end else if (req.opcode == bbc_pkg::OP_FLUSH) begin
              walk  <= head;
              steps <= '0;
              state <= S_FLUSH;
            end else if ((req.opcode == bbc_pkg::OP_RELEASE || req.opcode == bbc_pkg::OP_WRITE
                          || req.opcode == bbc_pkg::OP_DWRITE)
                         && req_in_range && busy_f[req_idx]) begin
              strobe <= 1'b1;
              if (req.opcode == bbc_pkg::OP_WRITE) begin
                result <= mk(bbc_pkg::ST_WRITEBACK, req_idx, cdev[req_idx], cblk[req_idx],
                             1'b0, 1'b1);
                dirty_f[req_idx] <= 1'b0;
                done_f[req_idx]  <= 1'b1;
              end else begin
                result <= mk(bbc_pkg::ST_DONE, '0, '0, '0, 1'b0, 1'b1);
                if (req.opcode == bbc_pkg::OP_DWRITE) begin
                  dirty_f[req_idx] <= 1'b1;
                  done_f[req_idx]  <= 1'b1;
                end
              end
              busy_f[req_idx] <= 1'b0;
              // append to tail
              prev_l[req_idx] <= tail;
              next_l[req_idx] <= NONE;
              if (tail != NONE) next_l[tail[IW-1:0]] <= LW'(32'(req_idx));
              else head <= LW'(32'(req_idx));
              tail <= LW'(32'(req_idx));
            end else begin
              strobe <= 1'b1;
              result <= mk(bbc_pkg::ST_DONE, '0, '0, '0, 1'b0, 1'b1);
            end
          end
        end
        S_SEARCH: begin
          if (pv[NUM_BUFFERS]) begin
            if (!ph[NUM_BUFFERS]) begin
              state <= S_ALLOC;
            end else begin
              strobe <= 1'b1;
              state  <= S_IDLE;
              if (busy_f[hit_idx]) begin
                result <= mk(bbc_pkg::ST_BUSY, hit_idx, '0, '0, 1'b0, 1'b1);
              end else if (done_f[hit_idx]) begin
                result <= mk(bbc_pkg::ST_HIT, hit_idx, '0, '0, 1'b0, 1'b1);
                busy_f[hit_idx] <= 1'b1;
                // unlink the hit buffer
                if (prev_l[hit_idx] != NONE)
                  next_l[prev_l[hit_idx][IW-1:0]] <= next_l[hit_idx];
                else head <= next_l[hit_idx];
                if (next_l[hit_idx] != NONE)
                  prev_l[next_l[hit_idx][IW-1:0]] <= prev_l[hit_idx];
                else tail <= prev_l[hit_idx];
                next_l[hit_idx] <= NONE;
                prev_l[hit_idx] <= NONE;
              end else begin
                result <= mk(bbc_pkg::ST_NONE, '0, '0, '0, 1'b0, 1'b1);
              end
            end
          end
        end
        S_ALLOC: begin
          strobe <= 1'b1;
          if (head == NONE) begin
            result <= mk(bbc_pkg::ST_NONE, '0, '0, '0, 1'b0, 1'b1);
            state  <= S_IDLE;
          end else if (dirty_f[head_idx]) begin
            result <= mk(bbc_pkg::ST_WRITEBACK, head_idx, cdev[head_idx], cblk[head_idx],
                         1'b0, 1'b0);
            dirty_f[head_idx] <= 1'b0;
            done_f[head_idx]  <= 1'b1;
            // head moves to tail; a single-entry list stays as it is
            if (head != tail) begin
              head                    <= next_l[head_idx];
              prev_l[next_l[head_idx][IW-1:0]] <= NONE;
              next_l[tail[IW-1:0]]    <= head;
              prev_l[head_idx]        <= tail;
              next_l[head_idx]        <= NONE;
              tail                    <= head;
            end
          end else begin
            result <= mk(bbc_pkg::ST_MISS, head_idx, '0, '0, is_read, 1'b1);
            busy_f[head_idx]  <= 1'b1;
            dirty_f[head_idx] <= 1'b0;
            done_f[head_idx]  <= is_read;
            head <= next_l[head_idx];
            if (next_l[head_idx] != NONE) prev_l[next_l[head_idx][IW-1:0]] <= NONE;
            else tail <= NONE;
            next_l[head_idx] <= NONE;
            prev_l[head_idx] <= NONE;
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (walk == NONE || steps == LW'(NUM_BUFFERS)) begin
            strobe <= 1'b1;
            result <= mk(bbc_pkg::ST_DONE, '0, '0, '0, 1'b0, 1'b1);
            state  <= S_IDLE;
          end else begin
            if (dirty_f[walk_idx]) begin
              strobe <= 1'b1;
              result <= mk(bbc_pkg::ST_WRITEBACK, walk_idx, cdev[walk_idx], cblk[walk_idx],
                           1'b0, 1'b0);
              dirty_f[walk_idx] <= 1'b0;
              done_f[walk_idx]  <= 1'b1;
            end
            walk  <= next_l[walk_idx];
            steps <= steps + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_reacts: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || strobe) else $error("request produced no activity");
  a_list_empty: assert property (@(posedge clk) disable iff (rst)
    (head == NONE) == (tail == NONE)) else $error("head and tail disagree on empty list");
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy) else $error("non-final result while idle");

endmodule
